>>> rtl/core/pfpq_pkg.sv
// ----------------------------------------------------------------------------
// pfpq_pkg
// Shared types, codes and the ordering key of the parity-first priority queue.
// ----------------------------------------------------------------------------
package pfpq_pkg;

	// Default number of stored values.
	localparam int CAPACITY = 64;

	localparam int VALUE_W = 32;

	typedef logic [1:0]                mode_t;
	typedef logic [1:0]                status_t;
	typedef logic [6:0]                count_t;
	typedef logic signed [VALUE_W-1:0] value_t;

	// Operation codes. The fourth code does nothing.
	localparam mode_t MODE_INSERT = 2'd0;
	localparam mode_t MODE_PEEK   = 2'd1;
	localparam mode_t MODE_REMOVE = 2'd2;

	// Result status codes.
	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_EMPTY = 2'd1;
	localparam status_t STATUS_FULL  = 2'd2;

	// Value returned by peek or remove on an empty queue.
	localparam value_t EMPTY_VALUE = -32'sd1;

	typedef struct packed {
		mode_t  mode;
		value_t value;
	} req_item_t;

	typedef struct packed {
		value_t  min_value;
		status_t status;
		count_t  count;
	} rsp_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_SCAN
	} state_t;

	// True when a sorts strictly before b: even values first, then ascending
	// signed order. Flipping the sign bit turns the signed order into an
	// unsigned one.
	function automatic logic key_less(value_t a, value_t b);
		logic [VALUE_W:0] ka;
		logic [VALUE_W:0] kb;
		ka = {a[0], ~a[VALUE_W-1], a[VALUE_W-2:0]};
		kb = {b[0], ~b[VALUE_W-1], b[VALUE_W-2:0]};
		return ka < kb;
	endfunction

endpackage

>>> rtl/core/pfpq_ram.sv
// ----------------------------------------------------------------------------
// pfpq_ram
// Value store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfpq_ram #(
	parameter int Capacity = pfpq_pkg::CAPACITY,
	localparam int AddrW = (Capacity > 1) ? $clog2(Capacity) : 1
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AddrW-1:0]     wr_addr,
	input  pfpq_pkg::value_t     wr_data,
	input  logic                 rd_en,
	input  logic [AddrW-1:0]     rd_addr,
	output pfpq_pkg::value_t     rd_data
);

	pfpq_pkg::value_t mem [Capacity];
	pfpq_pkg::value_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/core/parity_first_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// parity_first_priority_queue_unit
// Bounded priority queue of signed values: even values first, ascending
// within each parity. Insert, peek at the minimum, or remove the minimum.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Item fields
//  --------  -------------------  ----------------------------------
//  req       req_valid/req_stall  mode, value
//  rsp       rsp_valid/rsp_stall  min_value, status, count
//
//  An insert, a peek or an unused code sits in the output register in the
//  cycle after acceptance. A remove holds off the next item while the
//  states ST_MOVE_RD and ST_MOVE_WR move the last value into the freed
//  slot, then the single read port of the store sweeps the n remaining
//  entries to find the new minimum, where n is the count left after the
//  remove (none when it empties the queue). Reset clears only the count
//  and the control state; the store itself needs no clearing pass. A
//  stalled result holds the block in the idle state without losing work.
//
module parity_first_priority_queue_unit #(
	parameter int Capacity = pfpq_pkg::CAPACITY
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  pfpq_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output pfpq_pkg::rsp_item_t rsp
);

	localparam int AddrW = (Capacity > 1) ? $clog2(Capacity) : 1;
	localparam int FillW = $clog2(Capacity + 1);

	// Control and cached-minimum state.
	pfpq_pkg::state_t    state_q, state_d;
	logic [FillW-1:0]    fill_q, fill_d;
	pfpq_pkg::value_t    min_q, min_d;
	logic [AddrW-1:0]    min_idx_q, min_idx_d;
	logic [FillW-1:0]    scan_addr_q, scan_addr_d;
	logic                best_vld_q, best_vld_d;

	// Read pipeline of the sweep: marks which read data is arriving.
	logic                rd_vld_s1;
	logic [AddrW-1:0]    rd_addr_s1;

	// Output register.
	logic                out_valid_q, out_valid_d;
	pfpq_pkg::rsp_item_t out_q, out_d;
	logic                out_load;

	// Store ports.
	logic                ram_we;
	logic [AddrW-1:0]    ram_waddr;
	pfpq_pkg::value_t    ram_wdata;
	logic                ram_re;
	logic [AddrW-1:0]    ram_raddr;
	pfpq_pkg::value_t    ram_rdata;
	logic                scan_rd;

	logic                out_free;
	logic                accept;

	pfpq_ram #(
		.Capacity (Capacity)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// The output register frees up when it is empty or being taken.
	assign out_free  = !out_valid_q || !rsp_stall;
	assign req_stall = !((state_q == pfpq_pkg::ST_IDLE) && out_free);
	assign accept    = req_valid && !req_stall;

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfpq_pkg::ST_IDLE;
			fill_q      <= '0;
			scan_addr_q <= '0;
			best_vld_q  <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			fill_q      <= fill_d;
			scan_addr_q <= scan_addr_d;
			best_vld_q  <= best_vld_d;
			rd_vld_s1   <= scan_rd;
			out_valid_q <= out_valid_d;
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		min_q      <= min_d;
		min_idx_q  <= min_idx_d;
		rd_addr_s1 <= ram_raddr;
		if (out_load) begin
			out_q <= out_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		fill_d      = fill_q;
		min_d       = min_q;
		min_idx_d   = min_idx_q;
		scan_addr_d = scan_addr_q;
		best_vld_d  = best_vld_q;
		ram_we      = 1'b0;
		ram_waddr   = '0;
		ram_wdata   = '0;
		ram_re      = 1'b0;
		ram_raddr   = '0;
		scan_rd     = 1'b0;
		out_valid_d = out_valid_q && rsp_stall;
		out_load    = 1'b0;
		out_d       = out_q;

		case (state_q)
			pfpq_pkg::ST_IDLE: begin
				if (accept) begin
					out_load         = 1'b1;
					out_valid_d      = 1'b1;
					out_d.min_value  = '0;
					out_d.status     = pfpq_pkg::STATUS_OK;
					out_d.count      = pfpq_pkg::count_t'(fill_q);
					case (req.mode)
						pfpq_pkg::MODE_INSERT: begin
							if (fill_q >= FillW'(Capacity)) begin
								out_d.status = pfpq_pkg::STATUS_FULL;
							end else begin
								ram_we      = 1'b1;
								ram_waddr   = fill_q[AddrW-1:0];
								ram_wdata   = req.value;
								fill_d      = fill_q + FillW'(1);
								out_d.count = pfpq_pkg::count_t'(fill_d);
								// The cached minimum follows every insert.
								if (fill_q == '0 || pfpq_pkg::key_less(req.value, min_q)) begin
									min_d     = req.value;
									min_idx_d = fill_q[AddrW-1:0];
								end
							end
						end
						pfpq_pkg::MODE_PEEK: begin
							if (fill_q == '0) begin
								out_d.min_value = pfpq_pkg::EMPTY_VALUE;
								out_d.status    = pfpq_pkg::STATUS_EMPTY;
							end else begin
								out_d.min_value = min_q;
							end
						end
						pfpq_pkg::MODE_REMOVE: begin
							if (fill_q == '0) begin
								out_d.min_value = pfpq_pkg::EMPTY_VALUE;
								out_d.status    = pfpq_pkg::STATUS_EMPTY;
							end else begin
								out_d.min_value = min_q;
								fill_d          = fill_q - FillW'(1);
								out_d.count     = pfpq_pkg::count_t'(fill_d);
								state_d         = pfpq_pkg::ST_MOVE_RD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			pfpq_pkg::ST_MOVE_RD: begin
				// The count is already decremented, so it indexes the last value.
				ram_re    = 1'b1;
				ram_raddr = fill_q[AddrW-1:0];
				state_d   = pfpq_pkg::ST_MOVE_WR;
			end
			pfpq_pkg::ST_MOVE_WR: begin
				// The last value fills the freed slot; the sweep starts after
				// this write has landed.
				ram_we      = 1'b1;
				ram_waddr   = min_idx_q;
				ram_wdata   = ram_rdata;
				scan_addr_d = '0;
				best_vld_d  = 1'b0;
				if (fill_q == '0) begin
					state_d = pfpq_pkg::ST_IDLE;
				end else begin
					state_d = pfpq_pkg::ST_SCAN;
				end
			end
			pfpq_pkg::ST_SCAN: begin
				if (scan_addr_q < fill_q) begin
					ram_re      = 1'b1;
					ram_raddr   = scan_addr_q[AddrW-1:0];
					scan_rd     = 1'b1;
					scan_addr_d = scan_addr_q + FillW'(1);
				end
				if (rd_vld_s1) begin
					if (!best_vld_q || pfpq_pkg::key_less(ram_rdata, min_q)) begin
						min_d      = ram_rdata;
						min_idx_d  = rd_addr_s1;
						best_vld_d = 1'b1;
					end
				end
				// With every read issued, the data compared now is the last.
				if (scan_addr_q == fill_q) begin
					state_d = pfpq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pfpq_pkg::ST_IDLE;
			end
		endcase
	end

	// The count never exceeds the capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FillW'(Capacity))
		else $error("fill count above capacity");

	// Back in idle with values stored, the cached minimum points at a live slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pfpq_pkg::ST_IDLE && fill_q != '0) |-> (min_idx_q < fill_q[AddrW-1:0] ||
		FillW > AddrW && fill_q == FillW'(Capacity) || min_idx_q < AddrW'(fill_q)))
		else $error("cached minimum index outside stored values");

	// Every accepted item yields a result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid)
		else $error("accepted item produced no result");

	// A remove from a non-empty queue starts the move of the last value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.mode == pfpq_pkg::MODE_REMOVE && fill_q != '0)
		|=> state_q == pfpq_pkg::ST_MOVE_RD)
		else $error("remove did not start the refill sequence");

	// The sweep reads only live slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		scan_rd |-> scan_addr_q < fill_q)
		else $error("sweep read beyond the stored values");

endmodule
